// ===== hw/rtl/hbfd_pkg.sv =====
// Package for the HTTP body framing decoder.
// Holds phase and mode codes, error codes, field widths and byte helpers.
// No dependencies.
package hbfd_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ERR_W   = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned LEN_W   = 63;
    localparam int unsigned ODATA_W = 16;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_HT   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

    // Register indexes on the configuration port
    localparam logic REG_BODY_MODE = 1'b0;
    localparam logic REG_BODY_LEN  = 1'b1;

    // Body framing modes
    localparam logic [MODE_W-1:0] MODE_CLOSE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LENGTH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHUNKED = 2'd2;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EARLY_CLOSE = 3'd1;
    localparam logic [ERR_W-1:0] ERR_NONHEX      = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_NO_LF       = 3'd4;
    localparam logic [ERR_W-1:0] ERR_TOO_LARGE   = 3'd5;
    localparam logic [ERR_W-1:0] ERR_TAIL_NO_LF  = 3'd6;
    localparam logic [ERR_W-1:0] ERR_SHORT_BODY  = 3'd7;

    // Decoder phases
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_EOF  = 4'd1,
        PH_LEN  = 4'd2,
        PH_LWS  = 4'd3,
        PH_DIG  = 4'd4,
        PH_TAIL = 4'd5,
        PH_DATA = 4'd6,
        PH_CR   = 4'd7,
        PH_LF   = 4'd8,
        PH_DONE = 4'd9,
        PH_FAIL = 4'd10
    } t_phase;

    // Decoded hex character
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] c);
        t_hex h;
        h.valid = 1'b1;
        h.value = c[3:0];
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    // SP, HT or CR
    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SP) || (c == CH_HT) || (c == CH_CR);
    endfunction

endpackage

// ===== hw/rtl/http_body_framing_decoder.sv =====
// HTTP body framing decoder, top level.
// Depends on hbfd_pkg for phase, mode and error codes and the hex decoder.
//
// Usage:
//   Slave stream: one word per connection event. s_axis_tdata is the byte
//   received, s_axis_tuser set means the peer closed (the byte is ignored).
//   Master stream: zero or one word per event. m_axis_tdata carries the body
//   byte and the error code, m_axis_tuser flags a valid body byte and
//   m_axis_tlast marks the last word of the body (error words too).
//   Configuration: write body_mode (index 0) and body_len (index 1)
//   before the first event; they are sampled when that event is decoded.
// Pipeline and throughput:
//   An accepted event passes through the input register, then the decode
//   step that updates the framing state and loads the output register.
//   One event per cycle is sustained while m_axis_tready stays high; the
//   only wide path per cycle is the 63-bit count decrement and zero compare.
// Reset: i_rst_n (synchronous, active low) empties both registers, returns
//   the decoder to idle and restores body_mode 0 and body_len 1.
// Stall: while m_axis_tready is low a pending result holds; one more event
//   may sit in the input register, after which s_axis_tready drops.
module http_body_framing_decoder
    import hbfd_pkg::*;
#(
    parameter int unsigned HDR_CHARS = 20,
    parameter int unsigned SIZE_BITS = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [LEN_W-1:0]     i_cfg_data,
    // Slave stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] in_byte
    input  logic                 s_axis_tuser,   // [0] conn_closed
    // Master stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [ODATA_W-1:0]   m_axis_tdata,   // [7:0] out_byte, [10:8] error_code
    output logic                 m_axis_tuser,   // [0] has_byte
    output logic                 m_axis_tlast    // body_end
);

    localparam int unsigned DC_W = $clog2(HDR_CHARS + 1);

    // Configuration registers
    logic [MODE_W-1:0] r_body_mode;
    logic [LEN_W-1:0]  r_body_len;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_closed;

    // Framing state
    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_rem, n_rem;
    logic [DC_W-1:0]   r_dc, n_dc;
    logic              r_lz, n_lz;
    logic              r_ov, n_ov;
    logic              r_last, n_last;

    // Output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_has;
    logic              r_out_end;
    logic [ERR_W-1:0]  r_out_err;

    // Decode results
    logic              n_emit;
    logic [BYTE_W-1:0] n_byte;
    logic              n_has;
    logic              n_end;
    logic [ERR_W-1:0]  n_err;

    logic              out_free;
    logic              step_go;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign step_go       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step_go;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_mode <= MODE_CLOSE;
            r_body_len  <= LEN_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_BODY_MODE) begin
                r_body_mode <= i_cfg_data[MODE_W-1:0];
            end else begin
                r_body_len <= i_cfg_data;
            end
        end
    end

    // Input register: load on accept, drain on decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte   <= s_axis_tdata;
            r_in_closed <= s_axis_tuser;
        end
    end

    // Decode one event
    always_comb begin
        t_phase           ph;
        logic [LEN_W-1:0] rem;
        logic [LEN_W-1:0] rem_dec;
        logic [DC_W-1:0]  dc_inc;
        logic             lz;
        logic             ov;
        logic             last;
        t_hex             h;
        logic [BYTE_W-1:0] c;

        c       = r_in_byte;
        h       = hex_decode(c);
        ph      = r_phase;
        rem     = r_rem;
        lz      = r_lz;
        ov      = r_ov;
        last    = r_last;
        n_dc    = r_dc;

        // Latch the framing mode on the first event
        if (r_phase == PH_IDLE) begin
            if (r_body_mode == MODE_LENGTH) begin
                ph  = PH_LEN;
                rem = r_body_len;
            end else if (r_body_mode == MODE_CHUNKED) begin
                ph   = PH_LWS;
                rem  = '0;
                n_dc = '0;
                lz   = 1'b0;
                ov   = 1'b0;
                last = 1'b0;
            end else begin
                ph = PH_EOF;
            end
        end

        rem_dec = rem - LEN_W'(1);
        dc_inc  = n_dc + DC_W'(1);

        n_phase = ph;
        n_rem   = rem;
        n_lz    = lz;
        n_ov    = ov;
        n_last  = last;
        n_emit  = 1'b0;
        n_byte  = '0;
        n_has   = 1'b0;
        n_end   = 1'b0;
        n_err   = ERR_NONE;

        unique case (ph)
            PH_EOF: begin
                n_emit = 1'b1;
                if (r_in_closed) begin
                    n_phase = PH_DONE;
                    n_end   = 1'b1;
                end else begin
                    n_byte = c;
                    n_has  = 1'b1;
                end
            end
            PH_LEN: begin
                n_emit = 1'b1;
                if (rem == '0) begin
                    n_phase = PH_DONE;
                    n_end   = 1'b1;
                end else if (r_in_closed) begin
                    n_phase = PH_FAIL;
                    n_end   = 1'b1;
                    n_err   = ERR_SHORT_BODY;
                end else begin
                    n_rem  = rem_dec;
                    n_byte = c;
                    n_has  = 1'b1;
                    if (rem_dec == '0) begin
                        n_phase = PH_DONE;
                        n_end   = 1'b1;
                    end
                end
            end
            PH_LWS: begin
                if (r_in_closed) begin
                    n_phase = PH_FAIL;
                    n_emit  = 1'b1;
                    n_end   = 1'b1;
                    n_err   = ERR_EARLY_CLOSE;
                end else if (is_blank(c) || c == CH_LF) begin
                    // skip leading white space
                end else if (!h.valid) begin
                    n_phase = PH_FAIL;
                    n_emit  = 1'b1;
                    n_end   = 1'b1;
                    n_err   = ERR_NONHEX;
                end else begin
                    n_lz    = (c == CH_ZERO);
                    n_dc    = DC_W'(1);
                    n_rem   = LEN_W'(h.value);
                    n_phase = PH_DIG;
                end
            end
            PH_DIG: begin
                if (r_in_closed) begin
                    n_phase = PH_FAIL;
                    n_emit  = 1'b1;
                    n_end   = 1'b1;
                    n_err   = ERR_EARLY_CLOSE;
                end else if (n_dc == DC_W'(1) && lz && c == CH_ZERO) begin
                    // collapse repeated leading zeros
                end else if (h.valid) begin
                    n_dc = dc_inc;
                    if (dc_inc >= DC_W'(HDR_CHARS)) begin
                        n_phase = PH_FAIL;
                        n_emit  = 1'b1;
                        n_end   = 1'b1;
                        n_err   = ERR_TOO_LONG;
                    end else if (!ov) begin
                        if (rem[LEN_W-1:SIZE_BITS-4] != '0) begin
                            n_ov = 1'b1;
                        end else begin
                            n_rem = {rem[LEN_W-5:0], h.value};
                        end
                    end
                end else if (c == CH_LF) begin
                    if (ov) begin
                        n_phase = PH_FAIL;
                        n_emit  = 1'b1;
                        n_end   = 1'b1;
                        n_err   = ERR_TOO_LARGE;
                    end else if (rem == '0) begin
                        n_last  = 1'b1;
                        n_phase = PH_CR;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (is_blank(c)) begin
                    n_phase = PH_TAIL;
                end else begin
                    n_phase = PH_FAIL;
                    n_emit  = 1'b1;
                    n_end   = 1'b1;
                    n_err   = ERR_NO_LF;
                end
            end
            PH_TAIL: begin
                if (r_in_closed) begin
                    n_phase = PH_FAIL;
                    n_emit  = 1'b1;
                    n_end   = 1'b1;
                    n_err   = ERR_EARLY_CLOSE;
                end else if (c == CH_LF) begin
                    if (ov) begin
                        n_phase = PH_FAIL;
                        n_emit  = 1'b1;
                        n_end   = 1'b1;
                        n_err   = ERR_TOO_LARGE;
                    end else if (rem == '0) begin
                        n_last  = 1'b1;
                        n_phase = PH_CR;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (is_blank(c)) begin
                    // skip trailing white space
                end else begin
                    n_phase = PH_FAIL;
                    n_emit  = 1'b1;
                    n_end   = 1'b1;
                    n_err   = ERR_NO_LF;
                end
            end
            PH_DATA: begin
                n_emit = 1'b1;
                if (r_in_closed) begin
                    n_phase = PH_FAIL;
                    n_end   = 1'b1;
                    n_err   = ERR_SHORT_BODY;
                end else begin
                    n_rem  = rem_dec;
                    n_byte = c;
                    n_has  = 1'b1;
                    if (rem_dec == '0) begin
                        n_phase = PH_CR;
                    end
                end
            end
            PH_CR, PH_LF: begin
                if (r_in_closed) begin
                    n_phase = PH_FAIL;
                    n_emit  = 1'b1;
                    n_end   = 1'b1;
                    n_err   = ERR_EARLY_CLOSE;
                end else if (ph == PH_CR && c == CH_CR) begin
                    n_phase = PH_LF;
                end else if (c == CH_LF) begin
                    if (last) begin
                        n_phase = PH_DONE;
                        n_emit  = 1'b1;
                        n_end   = 1'b1;
                    end else begin
                        // start the next size line
                        n_phase = PH_LWS;
                        n_rem   = '0;
                        n_dc    = '0;
                        n_lz    = 1'b0;
                        n_ov    = 1'b0;
                    end
                end else begin
                    n_phase = PH_FAIL;
                    n_emit  = 1'b1;
                    n_end   = 1'b1;
                    n_err   = ERR_TAIL_NO_LF;
                end
            end
            default: begin
                // done, failed: drop the event
            end
        endcase
    end

    // Framing state: advance once per decoded event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rem   <= '0;
            r_dc    <= '0;
            r_lz    <= 1'b0;
            r_ov    <= 1'b0;
            r_last  <= 1'b0;
        end else if (step_go) begin
            r_phase <= n_phase;
            r_rem   <= n_rem;
            r_dc    <= n_dc;
            r_lz    <= n_lz;
            r_ov    <= n_ov;
            r_last  <= n_last;
        end
    end

    // Output register: load on decode, drain on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= n_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (step_go) begin
            r_out_byte <= n_byte;
            r_out_has  <= n_has;
            r_out_end  <= n_end;
            r_out_err  <= n_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(ODATA_W - BYTE_W - ERR_W)'(0), r_out_err, r_out_byte};
    assign m_axis_tuser  = r_out_has;
    assign m_axis_tlast  = r_out_end;

endmodule

// ===== hw/rtl/hbfd_checker.sv =====
// Port-level checks for the HTTP body framing decoder.
// Depends on hbfd_pkg; bound to http_body_framing_decoder at the end of file.
module hbfd_checker
    import hbfd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [ODATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               m_axis_tlast
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // Error words end the body and carry no byte
    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[10:8] != ERR_NONE |->
            m_axis_tlast && !m_axis_tuser && m_axis_tdata[7:0] == '0)
        else $error("error word malformed");

    // Nothing follows the end of the body
    a_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("result after end of body");

    // Empty output side never blocks input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind http_body_framing_decoder hbfd_checker u_hbfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb_http_body_framing_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP body framing decoder: one body per run, in a
// framing mode picked at random, decoded by an in-bench model and checked word by word.
// Depends on hbfd_pkg and http_body_framing_decoder.
module tb_http_body_framing_decoder;
    import hbfd_pkg::*;

    localparam int EVENT_TARGET = 800;
    localparam int IDLE_PCT     = 19;
    localparam int HDR_LIMIT    = 20;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};

    // Ways a chunked body can finish
    localparam int END_CLEAN      = 0;
    localparam int END_CLOSE_SIZE = 1;
    localparam int END_NONHEX     = 2;
    localparam int END_TOO_LONG   = 3;
    localparam int END_NO_LF      = 4;
    localparam int END_TOO_LARGE  = 5;
    localparam int END_TAIL_BAD   = 6;
    localparam int END_CLOSE_DATA = 7;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              closed;
    } t_conn_event;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              body_end;
        logic [ERR_W-1:0]  err;
    } t_body_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic [LEN_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [BYTE_W-1:0]  s_axis_tdata = '0;
    logic               s_axis_tuser = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [ODATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    http_body_framing_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] conn_closed
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] out_byte, [10:8] error_code
        .m_axis_tuser  (m_axis_tuser),   // [0] has_byte
        .m_axis_tlast  (m_axis_tlast)    // body_end
    );

    always #2 i_clk = ~i_clk;

    t_conn_event events_todo[$];
    t_body_word  body_words_due[$];
    t_body_word  want, seen;

    logic [BYTE_W-1:0] chunk_opener [0:23] = '{
        CH_SP, CH_HT, CH_CR, CH_LF, CH_ZERO, CH_ZERO, 8'h42, CH_SP, CH_HT, CH_CR, CH_LF,
        8'h00, 8'hFF, CH_LF, CH_CR, CH_SP, CH_HT, CH_ZERO, 8'h55, 8'hAA, 8'h80, 8'h7F,
        CH_CR, CH_LF};
    logic [BYTE_W-1:0] byte_extremes [0:5] = '{8'h00, 8'hFF, 8'h55, 8'hAA, CH_LF, CH_CR};

    int  n_accepted = 0;
    int  n_words = 0;
    int  n_bad = 0;
    int  n_cycles = 0;
    int  end_kind = END_CLEAN;
    logic feed_on = 1'b0;
    logic calm;

    // Idling stops for a stretch in the middle of the body
    assign calm = (n_accepted >= 300) && (n_accepted < 450);

    // ---------------------------------------------------------------- decoder model
    logic [MODE_W-1:0] shadow_mode = MODE_CLOSE;
    logic [LEN_W-1:0]  shadow_len = 1;
    t_phase            dec_phase = PH_IDLE;
    logic [LEN_W-1:0]  dec_left = '0;
    int unsigned       dec_digits = 0;
    logic              dec_lead_zero = 1'b0;
    logic              dec_overflow = 1'b0;
    logic              dec_last_chunk = 1'b0;

    function automatic int hex_nibble(input logic [BYTE_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
        return -1;
    endfunction

    function automatic logic blank(input logic [BYTE_W-1:0] c);
        return (c == CH_SP) || (c == CH_HT) || (c == CH_CR);
    endfunction

    task automatic put_word(input logic [BYTE_W-1:0] b, input logic has, input logic last,
                            input logic [ERR_W-1:0] err);
        t_body_word w;
        w.out_byte = b;
        w.has_byte = has;
        w.body_end = last;
        w.err = err;
        body_words_due.push_back(w);
    endtask

    task automatic fail_with(input logic [ERR_W-1:0] err);
        dec_phase = PH_FAIL;
        put_word('0, 1'b0, 1'b1, err);
    endtask

    task automatic open_chunk();
        dec_phase = PH_LWS;
        dec_left = '0;
        dec_digits = 0;
        dec_lead_zero = 1'b0;
        dec_overflow = 1'b0;
    endtask

    task automatic size_line_done();
        if (dec_overflow) begin
            fail_with(ERR_TOO_LARGE);
        end else if (dec_left == 0) begin
            dec_last_chunk = 1'b1;
            dec_phase = PH_CR;
        end else begin
            dec_phase = PH_DATA;
        end
    endtask

    task automatic tail_done();
        if (dec_last_chunk) begin
            dec_phase = PH_DONE;
            put_word('0, 1'b0, 1'b1, ERR_NONE);
        end else begin
            open_chunk();
        end
    endtask

    // Advance the model by one connection event, queueing any body word it yields
    task automatic decode_event(input logic [BYTE_W-1:0] c, input logic closed);
        int d;
        if (dec_phase == PH_IDLE) begin
            if (shadow_mode == MODE_LENGTH) begin
                dec_phase = PH_LEN;
                dec_left = shadow_len;
            end else if (shadow_mode == MODE_CHUNKED) begin
                open_chunk();
                dec_last_chunk = 1'b0;
            end else begin
                dec_phase = PH_EOF;
            end
        end
        d = hex_nibble(c);
        case (dec_phase)
            PH_EOF: begin
                if (closed) begin
                    dec_phase = PH_DONE;
                    put_word('0, 1'b0, 1'b1, ERR_NONE);
                end else begin
                    put_word(c, 1'b1, 1'b0, ERR_NONE);
                end
            end
            PH_LEN: begin
                if (dec_left == 0) begin
                    dec_phase = PH_DONE;
                    put_word('0, 1'b0, 1'b1, ERR_NONE);
                end else if (closed) begin
                    fail_with(ERR_SHORT_BODY);
                end else begin
                    dec_left = dec_left - 1'b1;
                    if (dec_left == 0) begin
                        dec_phase = PH_DONE;
                        put_word(c, 1'b1, 1'b1, ERR_NONE);
                    end else begin
                        put_word(c, 1'b1, 1'b0, ERR_NONE);
                    end
                end
            end
            PH_LWS: begin
                if (closed) begin
                    fail_with(ERR_EARLY_CLOSE);
                end else if (!(blank(c) || c == CH_LF)) begin
                    if (d < 0) begin
                        fail_with(ERR_NONHEX);
                    end else begin
                        dec_lead_zero = (c == CH_ZERO);
                        dec_digits = 1;
                        dec_left = LEN_W'(d);
                        dec_phase = PH_DIG;
                    end
                end
            end
            PH_DIG: begin
                if (closed) begin
                    fail_with(ERR_EARLY_CLOSE);
                end else if (dec_digits == 1 && dec_lead_zero && c == CH_ZERO) begin
                    // collapse repeated leading zeros
                end else if (d >= 0) begin
                    dec_digits++;
                    if (dec_digits >= HDR_LIMIT) begin
                        fail_with(ERR_TOO_LONG);
                    end else if (!dec_overflow) begin
                        if (dec_left[LEN_W-1:LEN_W-4] != 0) dec_overflow = 1'b1;
                        else dec_left = {dec_left[LEN_W-5:0], d[3:0]};
                    end
                end else if (c == CH_LF) begin
                    size_line_done();
                end else if (blank(c)) begin
                    dec_phase = PH_TAIL;
                end else begin
                    fail_with(ERR_NO_LF);
                end
            end
            PH_TAIL: begin
                if (closed) fail_with(ERR_EARLY_CLOSE);
                else if (c == CH_LF) size_line_done();
                else if (!blank(c)) fail_with(ERR_NO_LF);
            end
            PH_DATA: begin
                if (closed) begin
                    fail_with(ERR_SHORT_BODY);
                end else begin
                    dec_left = dec_left - 1'b1;
                    if (dec_left == 0) dec_phase = PH_CR;
                    put_word(c, 1'b1, 1'b0, ERR_NONE);
                end
            end
            PH_CR: begin
                if (closed) fail_with(ERR_EARLY_CLOSE);
                else if (c == CH_CR) dec_phase = PH_LF;
                else if (c == CH_LF) tail_done();
                else fail_with(ERR_TAIL_NO_LF);
            end
            PH_LF: begin
                if (closed) fail_with(ERR_EARLY_CLOSE);
                else if (c == CH_LF) tail_done();
                else fail_with(ERR_TAIL_NO_LF);
            end
            default: begin
            end
        endcase
    endtask

    // ---------------------------------------------------------------- stimulus builders
    task automatic add_byte(input logic [BYTE_W-1:0] b);
        events_todo.push_back('{b: b, closed: 1'b0});
    endtask

    task automatic add_close();
        logic [BYTE_W-1:0] junk;
        junk = BYTE_W'($urandom);
        events_todo.push_back('{b: junk, closed: 1'b1});
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        if (nib < 10) return CH_ZERO + nib;
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10;
    endfunction

    function automatic logic [BYTE_W-1:0] blank_char(input logic with_lf);
        case ($urandom_range(0, with_lf ? 3 : 2))
            0: return CH_SP;
            1: return CH_HT;
            2: return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Size line: optional white space, optional leading zeros, hex digits, blanks, LF
    task automatic add_size_line(input logic [LEN_W-1:0] sz);
        logic [63:0] v;
        int n_sig;
        v = {1'b0, sz};
        n_sig = 16;
        repeat ($urandom_range(0, 2)) add_byte(blank_char(1'b1));
        if (sz == 0) begin
            repeat ($urandom_range(1, 3)) add_byte(CH_ZERO);
        end else begin
            repeat ($urandom_range(0, 3)) add_byte(CH_ZERO);
            while (n_sig > 1 && v[4*(n_sig-1) +: 4] == 0) n_sig--;
            for (int k = n_sig - 1; k >= 0; k--) add_byte(hex_char(v[4*k +: 4]));
        end
        repeat ($urandom_range(0, 2)) add_byte(blank_char(1'b0));
        add_byte(CH_LF);
    endtask

    task automatic add_tail();
        if ($urandom_range(0, 1)) add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    task automatic add_chunk(input int sz);
        add_size_line(LEN_W'(sz));
        repeat (sz) add_byte(BYTE_W'($urandom_range(0, 255)));
        add_tail();
    endtask

    // Finish a chunked body, cleanly or with one of the framing faults
    task automatic add_chunked_ending(input int kind);
        case (kind)
            END_CLEAN: begin
                add_size_line('0);
                add_tail();
            end
            END_CLOSE_SIZE: begin
                if ($urandom_range(0, 1)) begin
                    add_byte(hex_char(4'($urandom_range(1, 15))));
                end else begin
                    add_size_line(2);
                    repeat (2) add_byte(BYTE_W'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1)) add_byte(CH_CR);
                end
                add_close();
            end
            END_NONHEX: add_byte($urandom_range(0, 1) ? 8'h47 : 8'h78);
            END_TOO_LONG: begin
                add_byte(hex_char(4'($urandom_range(1, 15))));
                repeat (HDR_LIMIT - 1) add_byte(hex_char(4'($urandom_range(0, 15))));
            end
            END_NO_LF: begin
                add_byte(hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 1)) add_byte(CH_SP);
                add_byte(8'h78);
            end
            END_TOO_LARGE: begin
                add_byte(hex_char(4'($urandom_range(8, 15))));
                repeat (15) add_byte(hex_char(4'($urandom_range(0, 15))));
                add_byte(CH_LF);
            end
            END_TAIL_BAD: begin
                add_size_line(3);
                repeat (3) add_byte(BYTE_W'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) add_byte(CH_CR);
                add_byte(8'h5A);
            end
            default: begin
                add_size_line(8);
                repeat (3) add_byte(BYTE_W'($urandom_range(0, 255)));
                add_close();
            end
        endcase
    endtask

    task automatic cfg_write(input logic idx, input logic [LEN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == REG_BODY_MODE) shadow_mode = val[MODE_W-1:0];
        else shadow_len = val;
    endtask

    // ---------------------------------------------------------------- sender and receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (feed_on && events_todo.size() != 0 &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= events_todo[0].b;
                    s_axis_tuser <= events_todo[0].closed;
                    events_todo.delete(0);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // check each delivered word against the oldest expected one
            if (m_axis_tvalid && m_axis_tready) begin
                seen.out_byte = m_axis_tdata[7:0];
                seen.err = m_axis_tdata[10:8];
                seen.has_byte = m_axis_tuser;
                seen.body_end = m_axis_tlast;
                if (body_words_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected word: byte %h has %b end %b err %0d",
                                 seen.out_byte, seen.has_byte, seen.body_end, seen.err);
                end else begin
                    want = body_words_due.pop_front();
                    if (seen.out_byte !== want.out_byte || seen.has_byte !== want.has_byte ||
                        seen.body_end !== want.body_end || seen.err !== want.err) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("word %0d: expected byte %h has %b end %b err %0d, %s",
                                     n_words, want.out_byte, want.has_byte, want.body_end,
                                     want.err, $sformatf("got byte %h has %b end %b err %0d",
                                     seen.out_byte, seen.has_byte, seen.body_end, seen.err));
                    end
                    n_words++;
                end
            end
            // predict the outcome of each accepted event
            if (s_axis_tvalid && s_axis_tready) begin
                decode_event(s_axis_tdata, s_axis_tuser);
                n_accepted <= n_accepted + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------- run control
    initial begin
        int pick;
        logic [MODE_W-1:0] mode_sel;
        logic [LEN_W-1:0] len_sel;

        pick = $urandom_range(0, 99);
        mode_sel = (pick < 60) ? MODE_CHUNKED : (pick < 75) ? MODE_LENGTH :
                   (pick < 88) ? MODE_CLOSE : MODE_SPARE;
        case ($urandom_range(0, 9))
            0: len_sel = '0;
            1: len_sel = 1;
            2: len_sel = LEN_MAX;
            3: len_sel = LEN_W'(EVENT_TARGET);
            default: len_sel = LEN_W'($urandom_range(2, 1000));
        endcase

        // build the whole event stream up front
        if (mode_sel == MODE_CHUNKED) begin
            foreach (chunk_opener[k]) add_byte(chunk_opener[k]);
            while (events_todo.size() < EVENT_TARGET)
                add_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                      : $urandom_range(1, 24));
            end_kind = $urandom_range(0, 11);
            end_kind = (end_kind < 5) ? END_CLEAN : end_kind - 4;
            add_chunked_ending(end_kind);
        end else begin
            if (mode_sel == MODE_LENGTH && len_sel == 0 && $urandom_range(0, 1)) add_close();
            foreach (byte_extremes[k]) add_byte(byte_extremes[k]);
            while (events_todo.size() < EVENT_TARGET)
                add_byte(BYTE_W'($urandom_range(0, 255)));
            add_close();
        end
        // events past the end of the body must be ignored
        repeat (3) add_byte(BYTE_W'($urandom_range(0, 255)));
        add_close();
        add_byte(BYTE_W'($urandom_range(0, 255)));

        // hold reset, then sweep the registers and leave the chosen setting
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cfg_write(REG_BODY_MODE, LEN_W'(MODE_SPARE));
        cfg_write(REG_BODY_LEN, LEN_MAX);
        cfg_write(REG_BODY_LEN, 1);
        cfg_write(REG_BODY_MODE, LEN_W'(MODE_CLOSE));
        cfg_write(REG_BODY_MODE, LEN_W'(mode_sel));
        cfg_write(REG_BODY_LEN, len_sel);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        feed_on <= 1'b1;

        // drain: all events in, all words out, then a margin for stray words
        while (events_todo.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (body_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // registers must not disturb a finished body
        cfg_write(REG_BODY_MODE, LEN_W'(MODE_CHUNKED));
        cfg_write(REG_BODY_LEN, LEN_MAX);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        n_bad += body_words_due.size();
        $display("Covered mode %0d, content length %0d, chunked ending kind %0d.",
                 mode_sel, len_sel, end_kind);
        $display("Sent %0d connection events, checked %0d body words, %0d mismatches.",
                 n_accepted, n_words, n_bad);
        if (n_bad == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hbfd_pkg.sv
hw/rtl/http_body_framing_decoder.sv
hw/rtl/hbfd_checker.sv
tb/tb_http_body_framing_decoder.sv
